>>> sv/reap_pkg.sv
`timescale 1ns / 1ps
package reap_pkg;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_BOUND    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_BOUND    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP           = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_STEP      = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_ENABLE    = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_WINDOW_MS = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OVER_PRESS_MS  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_START_POSITION = 4'd7;

	localparam logic signed [15:0] RST_LOWER_BOUND    = -16'sd32767;
	localparam logic signed [15:0] RST_UPPER_BOUND    = 16'sd32766;
	localparam logic [7:0]         RST_STEP           = 8'd1;
	localparam logic [7:0]         RST_FAST_STEP      = 8'd1;
	localparam logic [15:0]        RST_FAST_WINDOW_MS = 16'd300;
	localparam logic [15:0]        RST_OVER_PRESS_MS  = 16'd1000;

	typedef struct packed {
		logic        a_level;
		logic        b_level;
		logic [31:0] time_ms;
	} in_beat_t;

	typedef struct packed {
		logic signed [15:0] position;
		logic               moved;
	} out_beat_t;

	typedef struct packed {
		logic signed [15:0] lower_bound;
		logic signed [15:0] upper_bound;
		logic [7:0]         step;
		logic [7:0]         fast_step;
		logic               wrap_enable;
		logic [15:0]        fast_window_ms;
		logic [15:0]        over_press_ms;
		logic signed [15:0] start_position;
	} cfg_t;

	typedef struct packed {
		logic [31:0]        press_time;
		logic               press_pending;
		logic [31:0]        last_move_time;
		logic               reverse_dir;
		logic signed [15:0] position;
	} enc_state_t;

endpackage

>>> sv/rotary_encoder_position_accel_core.sv
`timescale 1ns / 1ps
// channel  | signals                          | direction
// ---------+----------------------------------+----------
// input    | in_valid, in_stall, in_data      | in
// output   | out_valid, out_stall, out_data   | out
// config   | cfg_we, cfg_index, cfg_data      | in
//
// one result beat per input beat, passed through the input register and then the
// result register; one beat is taken every cycle when not stalled.
// the state update (age compares, step add and bound test) is combinational and
// sits between the input register and the result register.
// reset clears control state and loads register reset values.
// a stall on the output holds the result; the input register then holds and
// in_stall rises only while it is full and cannot move on.
module rotary_encoder_position_accel_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  reap_pkg::in_beat_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output reap_pkg::out_beat_t                 out_data,
	input  logic                                cfg_we,
	input  logic [reap_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [reap_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import reap_pkg::*;

	logic       valid_s1;
	in_beat_t   item_s1;
	logic       valid_s2;
	out_beat_t  res_s2;
	cfg_t       cfg_q;
	enc_state_t st_q;
	enc_state_t st_nxt;
	out_beat_t  res_nxt;
	logic       advance;
	logic       start_ok;

	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	assign start_ok = ($signed(cfg_data) >= cfg_q.lower_bound) &&
	                  ($signed(cfg_data) <= cfg_q.upper_bound);

	reap_step u_step (
		.cfg  (cfg_q),
		.cur  (st_q),
		.item (item_s1),
		.nxt  (st_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_nxt;
		end else if (cfg_we && (cfg_index == REG_START_POSITION) && start_ok) begin
			st_q.position <= $signed(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lower_bound    <= RST_LOWER_BOUND;
			cfg_q.upper_bound    <= RST_UPPER_BOUND;
			cfg_q.step           <= RST_STEP;
			cfg_q.fast_step      <= RST_FAST_STEP;
			cfg_q.wrap_enable    <= 1'b0;
			cfg_q.fast_window_ms <= RST_FAST_WINDOW_MS;
			cfg_q.over_press_ms  <= RST_OVER_PRESS_MS;
			cfg_q.start_position <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOWER_BOUND:    cfg_q.lower_bound    <= $signed(cfg_data);
				REG_UPPER_BOUND:    cfg_q.upper_bound    <= $signed(cfg_data);
				REG_STEP:           cfg_q.step           <= cfg_data[7:0];
				REG_FAST_STEP:      cfg_q.fast_step      <= cfg_data[7:0];
				REG_WRAP_ENABLE:    cfg_q.wrap_enable    <= cfg_data[0];
				REG_FAST_WINDOW_MS: cfg_q.fast_window_ms <= cfg_data;
				REG_OVER_PRESS_MS:  cfg_q.over_press_ms  <= cfg_data;
				REG_START_POSITION: cfg_q.start_position <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// after an advance, the result beat shows the position that the state then holds
	a_res_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (out_valid && (out_data.position == st_q.position)))
		else $error("result position differs from held position");

	// no pending press leaves a stale timestamp behind
	a_idle_press_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.press_pending |-> (st_q.press_time == 32'd0))
		else $error("press time set without a pending press");

	// an empty input register never stalls the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled while input register is empty");

	// a stalled input register means the result register is full and held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s2 && out_stall))
		else $error("input stalled without an output stall");

endmodule

>>> sv/reap_step.sv
`timescale 1ns / 1ps
module reap_step (
	input  reap_pkg::cfg_t       cfg,
	input  reap_pkg::enc_state_t cur,
	input  reap_pkg::in_beat_t   item,
	output reap_pkg::enc_state_t nxt,
	output reap_pkg::out_beat_t  res
);
	import reap_pkg::*;

	logic [31:0]        press_age;
	logic [31:0]        move_age;
	logic [31:0]        over_ms;
	logic [7:0]         inc;
	logic [7:0]         max_step;
	logic signed [17:0] pos_w;
	logic signed [17:0] inc_w;
	logic signed [17:0] lo_w;
	logic signed [17:0] hi_w;
	logic signed [17:0] p_sum;
	logic signed [17:0] p_up;
	logic signed [17:0] p_fin;

	assign press_age = item.time_ms - cur.press_time;
	assign move_age  = item.time_ms - cur.last_move_time;
	assign over_ms   = {16'd0, cfg.over_press_ms};
	assign max_step  = (cfg.fast_step > cfg.step) ? cfg.fast_step : cfg.step;
	assign inc       = (move_age < {16'd0, cfg.fast_window_ms}) ? max_step : cfg.step;

	// position math at 18 bits so nothing overflows near the limits
	assign pos_w = {{2{cur.position[15]}}, cur.position};
	assign inc_w = signed'({10'd0, inc});
	assign lo_w  = {{2{cfg.lower_bound[15]}}, cfg.lower_bound};
	assign hi_w  = {{2{cfg.upper_bound[15]}}, cfg.upper_bound};
	assign p_sum = cur.reverse_dir ? (pos_w - inc_w) : (pos_w + inc_w);

	// upper test first, lower test on its result
	always_comb begin
		p_up = p_sum;
		if (p_sum > hi_w) begin
			p_up = cfg.wrap_enable ? lo_w : hi_w;
		end
		p_fin = p_up;
		if (p_up < lo_w) begin
			p_fin = cfg.wrap_enable ? hi_w : lo_w;
		end
	end

	always_comb begin
		nxt = cur;
		if (!item.a_level) begin
			if (!cur.press_pending || (press_age > over_ms)) begin
				nxt.press_time    = item.time_ms;
				nxt.press_pending = 1'b1;
				nxt.reverse_dir   = item.b_level;
			end
		end else if (cur.press_pending) begin
			if (press_age < over_ms) begin
				nxt.last_move_time = item.time_ms;
				nxt.position       = p_fin[15:0];
			end
			nxt.press_pending = 1'b0;
			nxt.press_time    = 32'd0;
		end
		res.position = nxt.position;
		res.moved    = (nxt.position != cur.position);
	end

endmodule
